// ===== design/console_line_discipline_top_macros.svh =====
// ----------------------------------------------------------------------------
// console line discipline assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_DISCIPLINE_TOP_MACROS_SVH
`define CONSOLE_LINE_DISCIPLINE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cld assertion failed");

// consequent must hold in the cycle after the antecedent
`define CLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cld assertion failed");

`endif

// ===== design/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg
// shared types, codes and constants of the console line discipline
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int RING_DEPTH_DEFAULT = 128;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_MODE = 2'd2;

    localparam logic [7:0] KEY_KILL = 8'h15;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_DEL  = 8'h7F;
    localparam logic [7:0] KEY_CR   = 8'h0D;
    localparam logic [7:0] KEY_LF   = 8'h0A;
    localparam logic [7:0] KEY_EOF  = 8'h04;
    localparam logic [7:0] KEY_DUMP = 8'h10;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_DUMP,
        CMD_KILL,
        CMD_ERASE,
        CMD_NUL,
        CMD_CR,
        CMD_TERM,
        CMD_CHAR,
        CMD_READ,
        CMD_MODE
    } cmd_t;

    typedef enum logic [3:0] {
        ST_STORED  = 4'd0,
        ST_ECHOED  = 4'd1,
        ST_ERASED  = 4'd2,
        ST_DUMP    = 4'd3,
        ST_IGNORED = 4'd4,
        ST_DATA    = 4'd5,
        ST_EMPTY   = 4'd6,
        ST_EOF     = 4'd7,
        ST_EOF_KEPT = 4'd8,
        ST_MODE_OK = 4'd9,
        ST_REFUSED = 4'd10
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       first;
        logic       mode_req;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

// ===== design/cld_front.sv =====
// ----------------------------------------------------------------------------
// cld_front
// takes commands, sorts received bytes into classes and queues them
// ----------------------------------------------------------------------------
module cld_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        op,
    input  logic [7:0]        rx_byte,
    input  logic              first_of_read,
    input  logic              mode_req,
    input  cld_pkg::qstat_t   qstat,
    output cld_pkg::push_t    push,
    output logic              pending
);

    logic           pending_reg;
    logic           pending_next;
    cld_pkg::item_t item_reg;
    cld_pkg::item_t item_next;
    logic           accept;

    function automatic cld_pkg::cmd_t classify(logic [1:0] o, logic [7:0] b);
        cld_pkg::cmd_t c;
        c = cld_pkg::CMD_NOP;
        case (o)
            cld_pkg::OP_RX:
            begin
                if (b == cld_pkg::KEY_DUMP)
                    c = cld_pkg::CMD_DUMP;
                else if (b == cld_pkg::KEY_KILL)
                    c = cld_pkg::CMD_KILL;
                else if (b == cld_pkg::KEY_BS || b == cld_pkg::KEY_DEL)
                    c = cld_pkg::CMD_ERASE;
                else if (b == 8'h00)
                    c = cld_pkg::CMD_NUL;
                else if (b == cld_pkg::KEY_CR)
                    c = cld_pkg::CMD_CR;
                else if (b == cld_pkg::KEY_LF || b == cld_pkg::KEY_EOF)
                    c = cld_pkg::CMD_TERM;
                else
                    c = cld_pkg::CMD_CHAR;
            end
            cld_pkg::OP_READ: c = cld_pkg::CMD_READ;
            cld_pkg::OP_MODE: c = cld_pkg::CMD_MODE;
            default:          c = cld_pkg::CMD_NOP;
        endcase
        return c;
    endfunction

    assign accept = start && !busy;

    always_comb
    begin
        item_next          = item_reg;
        pending_next       = pending_reg;
        if (accept)
        begin
            item_next.cmd      = classify(op, rx_byte);
            item_next.data     = rx_byte;
            item_next.first    = first_of_read;
            item_next.mode_req = mode_req;
            pending_next       = 1'b1;
        end
        else if (pending_reg && !qstat.full)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else
            pending_reg <= pending_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push.valid = pending_reg && !qstat.full;
    assign push.item  = item_reg;
    assign pending    = pending_reg;

endmodule

// ===== design/cld_queue.sv =====
// ----------------------------------------------------------------------------
// cld_queue
// short fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module cld_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  cld_pkg::push_t  push,
    input  logic            pop,
    output cld_pkg::item_t  head,
    output cld_pkg::qstat_t qstat
);

    localparam int PTRW = (cld_pkg::QUEUE_DEPTH > 1) ? $clog2(cld_pkg::QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(cld_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTRW-1:0] LAST = PTRW'(cld_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(cld_pkg::QUEUE_DEPTH);

    cld_pkg::item_t  entry_reg [cld_pkg::QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign do_push = push.valid && (count_reg != FULL_COUNT);
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.item;
    end

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == FULL_COUNT);

endmodule

// ===== design/cld_back.sv =====
// ----------------------------------------------------------------------------
// cld_back
// ring store, indices and mode; carries out one queued command at a time
// ----------------------------------------------------------------------------
module cld_back
#(
    parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cld_pkg::item_t head,
    input  logic           q_empty,
    output logic           pop,
    output logic           back_busy,
    output logic           result_valid,
    output logic [3:0]     status,
    output logic [7:0]     echo_byte,
    output logic [7:0]     erase_count,
    output logic [7:0]     read_byte,
    output logic           read_done,
    output logic           wake_reader
);

    localparam int SLOTW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SLOTW-1:0] LAST_SLOT = SLOTW'(RING_DEPTH - 1);

    // index runs modulo twice the depth: wrap flag plus slot
    typedef struct packed {
        logic             wrap;
        logic [SLOTW-1:0] slot;
    } idx_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ_WAIT,
        B_KILL_CHK
    } bstate_t;

    function automatic idx_t idx_inc(idx_t i);
        idx_t r;
        r = i;
        if (i.slot == LAST_SLOT)
        begin
            r.slot = '0;
            r.wrap = ~i.wrap;
        end
        else
            r.slot = i.slot + 1'b1;
        return r;
    endfunction

    function automatic idx_t idx_dec(idx_t i);
        idx_t r;
        r = i;
        if (i.slot == '0)
        begin
            r.slot = LAST_SLOT;
            r.wrap = ~i.wrap;
        end
        else
            r.slot = i.slot - 1'b1;
        return r;
    endfunction

    function automatic logic ring_full(idx_t e, idx_t r);
        return (e.wrap != r.wrap) && (e.slot == r.slot);
    endfunction

    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_wr_en;
    logic [SLOTW-1:0] mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [SLOTW-1:0] mem_rd_addr;

    bstate_t          state_reg, state_next;
    idx_t             read_reg, read_next;
    idx_t             commit_reg, commit_next;
    idx_t             edit_reg, edit_next;
    logic             raw_reg, raw_next;
    logic             first_reg, first_next;
    logic [7:0]       erase_reg, erase_next;
    logic             valid_reg, valid_next;
    cld_pkg::status_t status_reg, status_next;
    logic [7:0]       echo_reg, echo_next;
    logic [7:0]       erase_out_reg, erase_out_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic             done_reg, done_next;
    logic             wake_reg, wake_next;

    logic             byte_cmd;
    idx_t             edit_inc;
    idx_t             edit_dec;
    idx_t             edit_dec2;
    idx_t             read_inc;
    logic [7:0]       cooked_byte;
    logic [7:0]       erase_sat;

    assign edit_inc  = idx_inc(edit_reg);
    assign edit_dec  = idx_dec(edit_reg);
    assign edit_dec2 = idx_dec(edit_dec);
    assign read_inc  = idx_inc(read_reg);
    assign erase_sat = (erase_reg == 8'hFF) ? erase_reg : erase_reg + 1'b1;
    assign cooked_byte = (head.cmd == cld_pkg::CMD_CR) ? cld_pkg::KEY_LF : head.data;
    assign byte_cmd  = (head.cmd == cld_pkg::CMD_KILL) || (head.cmd == cld_pkg::CMD_ERASE)
                    || (head.cmd == cld_pkg::CMD_CR) || (head.cmd == cld_pkg::CMD_TERM)
                    || (head.cmd == cld_pkg::CMD_CHAR);

    always_comb
    begin
        state_next     = state_reg;
        read_next      = read_reg;
        commit_next    = commit_reg;
        edit_next      = edit_reg;
        raw_next       = raw_reg;
        first_next     = first_reg;
        erase_next     = erase_reg;
        valid_next     = 1'b0;
        status_next    = cld_pkg::ST_IGNORED;
        echo_next      = 8'h00;
        erase_out_next = 8'h00;
        rbyte_next     = 8'h00;
        done_next      = 1'b0;
        wake_next      = 1'b0;
        pop            = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = edit_reg.slot;
        mem_wr_data    = head.data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = read_reg.slot;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    if (raw_reg && byte_cmd)
                    begin
                        if (!ring_full(edit_reg, read_reg))
                        begin
                            mem_wr_en   = 1'b1;
                            edit_next   = edit_inc;
                            commit_next = edit_inc;
                            status_next = cld_pkg::ST_STORED;
                            wake_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        case (head.cmd)
                            cld_pkg::CMD_DUMP: status_next = cld_pkg::ST_DUMP;
                            cld_pkg::CMD_KILL:
                            begin
                                status_next = cld_pkg::ST_ERASED;
                                if (edit_reg != commit_reg)
                                begin
                                    // walk back one entry per cycle
                                    valid_next  = 1'b0;
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = edit_dec.slot;
                                    erase_next  = 8'h00;
                                    state_next  = B_KILL_CHK;
                                end
                            end
                            cld_pkg::CMD_ERASE:
                            begin
                                status_next = cld_pkg::ST_ERASED;
                                if (edit_reg != commit_reg)
                                begin
                                    edit_next      = edit_dec;
                                    erase_out_next = 8'h01;
                                end
                            end
                            cld_pkg::CMD_CR, cld_pkg::CMD_TERM, cld_pkg::CMD_CHAR:
                            begin
                                if (!ring_full(edit_reg, read_reg))
                                begin
                                    mem_wr_en   = 1'b1;
                                    mem_wr_data = cooked_byte;
                                    edit_next   = edit_inc;
                                    echo_next   = cooked_byte;
                                    status_next = cld_pkg::ST_ECHOED;
                                    if (head.cmd != cld_pkg::CMD_CHAR
                                        || ring_full(edit_inc, read_reg))
                                    begin
                                        commit_next = edit_inc;
                                        wake_next   = 1'b1;
                                    end
                                end
                            end
                            cld_pkg::CMD_READ:
                            begin
                                if (read_reg == commit_reg)
                                    status_next = cld_pkg::ST_EMPTY;
                                else
                                begin
                                    valid_next  = 1'b0;
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = read_reg.slot;
                                    first_next  = head.first;
                                    state_next  = B_READ_WAIT;
                                end
                            end
                            cld_pkg::CMD_MODE:
                            begin
                                status_next = cld_pkg::ST_MODE_OK;
                                if (head.mode_req)
                                begin
                                    if (!raw_reg)
                                    begin
                                        if (read_reg != commit_reg || commit_reg != edit_reg)
                                            status_next = cld_pkg::ST_REFUSED;
                                        else
                                            raw_next = 1'b1;
                                    end
                                end
                                else if (raw_reg)
                                begin
                                    // back to cooked drops whatever is unread
                                    raw_next    = 1'b0;
                                    read_next   = edit_reg;
                                    commit_next = edit_reg;
                                    wake_next   = 1'b1;
                                end
                            end
                            default: status_next = cld_pkg::ST_IGNORED;
                        endcase
                    end
                end
            end

            B_READ_WAIT:
            begin
                valid_next = 1'b1;
                state_next = B_IDLE;
                if (!raw_reg && rd_data_reg == cld_pkg::KEY_EOF)
                begin
                    done_next = 1'b1;
                    if (first_reg)
                    begin
                        read_next   = read_inc;
                        status_next = cld_pkg::ST_EOF;
                    end
                    else
                        status_next = cld_pkg::ST_EOF_KEPT;
                end
                else
                begin
                    read_next   = read_inc;
                    status_next = cld_pkg::ST_DATA;
                    rbyte_next  = rd_data_reg;
                    if (raw_reg)
                        done_next = (read_inc == commit_reg);
                    else
                        done_next = (rd_data_reg == cld_pkg::KEY_LF);
                end
            end

            B_KILL_CHK:
            begin
                status_next = cld_pkg::ST_ERASED;
                if (rd_data_reg == cld_pkg::KEY_LF)
                begin
                    valid_next     = 1'b1;
                    erase_out_next = erase_reg;
                    state_next     = B_IDLE;
                end
                else
                begin
                    edit_next  = edit_dec;
                    erase_next = erase_sat;
                    if (edit_dec == commit_reg)
                    begin
                        valid_next     = 1'b1;
                        erase_out_next = erase_sat;
                        state_next     = B_IDLE;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = edit_dec2.slot;
                    end
                end
            end

            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            read_reg      <= '0;
            commit_reg    <= '0;
            edit_reg      <= '0;
            raw_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            first_reg     <= 1'b0;
            erase_reg     <= 8'h00;
            status_reg    <= cld_pkg::ST_IGNORED;
            echo_reg      <= 8'h00;
            erase_out_reg <= 8'h00;
            rbyte_reg     <= 8'h00;
            done_reg      <= 1'b0;
            wake_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            read_reg      <= read_next;
            commit_reg    <= commit_next;
            edit_reg      <= edit_next;
            raw_reg       <= raw_next;
            valid_reg     <= valid_next;
            first_reg     <= first_next;
            erase_reg     <= erase_next;
            status_reg    <= status_next;
            echo_reg      <= echo_next;
            erase_out_reg <= erase_out_next;
            rbyte_reg     <= rbyte_next;
            done_reg      <= done_next;
            wake_reg      <= wake_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            ring_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= ring_mem[mem_rd_addr];
    end

    assign back_busy    = (state_reg != B_IDLE);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign echo_byte    = echo_reg;
    assign erase_count  = erase_out_reg;
    assign read_byte    = rbyte_reg;
    assign read_done    = done_reg;
    assign wake_reader  = wake_reg;

endmodule

// ===== design/console_line_discipline_top.sv =====
// ----------------------------------------------------------------------------
// console_line_discipline_top
// console input line discipline, cooked and raw modes
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with result_valid high, and it cannot be held
// off. Each command passes the front register, the queue and the back end on
// its way to the result strobe; a read of stored data also waits in B_READ_WAIT
// for the ring read. A kill-line command walks back through the current line
// one ring entry per cycle over the registered-read ring memory, so it takes
// longer the more bytes it erases. busy stays high from a start transfer until
// its result is shown. No clearing pass follows reset.
module console_line_discipline_top
#(
    parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    input  logic       first_of_read,
    input  logic       mode_req,
    output logic       result_valid,
    output logic [3:0] status,
    output logic [7:0] echo_byte,
    output logic [7:0] erase_count,
    output logic [7:0] read_byte,
    output logic       read_done,
    output logic       wake_reader
);

    cld_pkg::push_t  push;
    cld_pkg::qstat_t qstat;
    cld_pkg::item_t  head;
    logic            pop;
    logic            pending;
    logic            back_busy;

    assign busy = pending || !qstat.empty || back_busy;

    cld_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .rx_byte       (rx_byte),
        .first_of_read (first_of_read),
        .mode_req      (mode_req),
        .qstat         (qstat),
        .push          (push),
        .pending       (pending)
    );

    cld_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    cld_back
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (qstat.empty),
        .pop          (pop),
        .back_busy    (back_busy),
        .result_valid (result_valid),
        .status       (status),
        .echo_byte    (echo_byte),
        .erase_count  (erase_count),
        .read_byte    (read_byte),
        .read_done    (read_done),
        .wake_reader  (wake_reader)
    );

endmodule

// ===== design/cld_checker.sv =====
// ----------------------------------------------------------------------------
// cld_checker
// port-level checks on the console line discipline, bound to the top level
// ----------------------------------------------------------------------------
`include "console_line_discipline_top_macros.svh"

module cld_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [3:0] status,
    input logic [7:0] echo_byte,
    input logic       read_done
);

    // a start transfer raises busy, and busy is low while a result is shown
    `CLD_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `CLD_ASSERT_NOW(a_result_idle, result_valid, !busy)
    `CLD_ASSERT_NOW(a_status_range, result_valid, status <= cld_pkg::ST_REFUSED)
    `CLD_ASSERT_NOW(a_echo_zero, result_valid && status != cld_pkg::ST_ECHOED, echo_byte == 8'h00)
    `CLD_ASSERT_NOW(a_empty_waits, result_valid && status == cld_pkg::ST_EMPTY, !read_done)

endmodule

bind console_line_discipline_top cld_checker u_cld_checker (.*);

// ===== tb/tb_console_line_discipline_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_console_line_discipline_top
// drives received bytes, reads and mode changes into the line discipline,
// predicts every result with its own ring and index model, and compares the
// strobed results field by field in order
// ----------------------------------------------------------------------------
module tb_console_line_discipline_top;

    localparam int         LINE_RING_DEPTH = cld_pkg::RING_DEPTH_DEFAULT;
    localparam logic [1:0] OP_NONE         = 2'd3;
    localparam int         DIRECTED_ITEMS  = 25;
    localparam int         RANDOM_ITEMS    = 900;
    localparam int         MAX_PRINTED     = 60;

    typedef struct packed {
        cld_pkg::status_t status;
        logic [7:0]       echo;
        logic [7:0]       erase;
        logic [7:0]       rbyte;
        logic             done;
        logic             wake;
    } outcome_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       first;
        logic       mode;
        logic       typed;
        outcome_t   res;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       first_of_read;
    logic       mode_req;
    logic       result_valid;
    logic [3:0] status;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic [7:0] read_byte;
    logic       read_done;
    logic       wake_reader;

    // own copy of the line discipline state
    logic [7:0] ring_mem [0:LINE_RING_DEPTH-1];
    logic [7:0] rd_idx;
    logic [7:0] cm_idx;
    logic [7:0] ed_idx;
    logic       raw_mode;

    outcome_t   due_results [$];
    row_t       plan [$];
    int         mismatch_count;
    int         sent_count;
    logic       next_first;

    console_line_discipline_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .rx_byte       (rx_byte),
        .first_of_read (first_of_read),
        .mode_req      (mode_req),
        .result_valid  (result_valid),
        .status        (status),
        .echo_byte     (echo_byte),
        .erase_count   (erase_count),
        .read_byte     (read_byte),
        .read_done     (read_done),
        .wake_reader   (wake_reader)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

    // one command through the cooked / raw line discipline
    function automatic outcome_t discipline_step(input logic [1:0] o, input logic [7:0] b,
                                                 input logic f, input logic m);
        outcome_t   r;
        logic [7:0] c;
        logic [7:0] prev;
        logic [7:0] used;
        r = '0;
        r.status = cld_pkg::ST_IGNORED;
        c = b;
        used = ed_idx - rd_idx;
        case (o)
            cld_pkg::OP_RX:
            begin
                if (c == cld_pkg::KEY_DUMP)
                begin
                    r.status = cld_pkg::ST_DUMP;
                end
                else if (raw_mode)
                begin
                    if (c != 8'h00 && used < LINE_RING_DEPTH)
                    begin
                        ring_mem[ed_idx % LINE_RING_DEPTH] = c;
                        ed_idx = ed_idx + 8'd1;
                        cm_idx = ed_idx;
                        r.status = cld_pkg::ST_STORED;
                        r.wake = 1'b1;
                    end
                end
                else if (c == cld_pkg::KEY_KILL)
                begin
                    prev = ed_idx - 8'd1;
                    while (ed_idx != cm_idx
                           && ring_mem[prev % LINE_RING_DEPTH] != cld_pkg::KEY_LF)
                    begin
                        ed_idx = prev;
                        if (r.erase != 8'hFF)
                            r.erase = r.erase + 8'd1;
                        prev = ed_idx - 8'd1;
                    end
                    r.status = cld_pkg::ST_ERASED;
                end
                else if (c == cld_pkg::KEY_BS || c == cld_pkg::KEY_DEL)
                begin
                    if (ed_idx != cm_idx)
                    begin
                        ed_idx = ed_idx - 8'd1;
                        r.erase = 8'd1;
                    end
                    r.status = cld_pkg::ST_ERASED;
                end
                else if (c != 8'h00 && used < LINE_RING_DEPTH)
                begin
                    if (c == cld_pkg::KEY_CR)
                        c = cld_pkg::KEY_LF;
                    r.echo = c;
                    r.status = cld_pkg::ST_ECHOED;
                    ring_mem[ed_idx % LINE_RING_DEPTH] = c;
                    ed_idx = ed_idx + 8'd1;
                    used = ed_idx - rd_idx;
                    // a line goes to readers on newline, end of file or a full ring
                    if (c == cld_pkg::KEY_LF || c == cld_pkg::KEY_EOF
                        || used == LINE_RING_DEPTH)
                    begin
                        cm_idx = ed_idx;
                        r.wake = 1'b1;
                    end
                end
            end
            cld_pkg::OP_READ:
            begin
                if (rd_idx == cm_idx)
                begin
                    r.status = cld_pkg::ST_EMPTY;
                end
                else
                begin
                    c = ring_mem[rd_idx % LINE_RING_DEPTH];
                    if (!raw_mode && c == cld_pkg::KEY_EOF)
                    begin
                        // end of file is only consumed at the head of a read call
                        if (f)
                        begin
                            rd_idx = rd_idx + 8'd1;
                            r.status = cld_pkg::ST_EOF;
                        end
                        else
                        begin
                            r.status = cld_pkg::ST_EOF_KEPT;
                        end
                        r.done = 1'b1;
                    end
                    else
                    begin
                        rd_idx = rd_idx + 8'd1;
                        r.status = cld_pkg::ST_DATA;
                        r.rbyte = c;
                        r.done = raw_mode ? (rd_idx == cm_idx) : (c == cld_pkg::KEY_LF);
                    end
                end
            end
            cld_pkg::OP_MODE:
            begin
                r.status = cld_pkg::ST_MODE_OK;
                if (m)
                begin
                    if (!raw_mode)
                    begin
                        if (rd_idx != cm_idx || cm_idx != ed_idx)
                            r.status = cld_pkg::ST_REFUSED;
                        else
                            raw_mode = 1'b1;
                    end
                end
                else if (raw_mode)
                begin
                    // back to cooked drops whatever is unread
                    raw_mode = 1'b0;
                    rd_idx = ed_idx;
                    cm_idx = ed_idx;
                    r.wake = 1'b1;
                end
            end
            default:
            begin
                r.status = cld_pkg::ST_IGNORED;
            end
        endcase
        return r;
    endfunction

    function automatic row_t mk_row(input logic [1:0] o, input logic [7:0] b, input logic f,
                                    input logic m, input logic typed,
                                    input cld_pkg::status_t st,
                                    input int echo, input int erase,
                                    input int rbyte, input int done,
                                    input int wake);
        row_t r;
        r.op = o;
        r.data = b;
        r.first = f;
        r.mode = m;
        r.typed = typed;
        r.res.status = st;
        r.res.echo = 8'(echo);
        r.res.erase = 8'(erase);
        r.res.rbyte = 8'(rbyte);
        r.res.done = 1'(done);
        r.res.wake = 1'(wake);
        return r;
    endfunction

    function automatic logic [7:0] text_char();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // mostly plain text, with some editing keys and arbitrary bytes
    function automatic logic [7:0] edit_key();
        int p;
        p = $urandom_range(0, 99);
        if (p < 85)
            return text_char();
        else if (p < 88)
            return cld_pkg::KEY_BS;
        else if (p < 91)
            return cld_pkg::KEY_DEL;
        else if (p < 94)
            return cld_pkg::KEY_KILL;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, status", 8'(status), 8'h00);
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 8'(status), 8'(want.status));
                if (echo_byte !== want.echo)
                    report_mismatch("echo_byte", echo_byte, want.echo);
                if (erase_count !== want.erase)
                    report_mismatch("erase_count", erase_count, want.erase);
                if (read_byte !== want.rbyte)
                    report_mismatch("read_byte", read_byte, want.rbyte);
                if (read_done !== want.done)
                    report_mismatch("read_done", 8'(read_done), 8'(want.done));
                if (wake_reader !== want.wake)
                    report_mismatch("wake_reader", 8'(wake_reader), 8'(want.wake));
            end
        end
    end

    // one command transfer; a typed row overrides the predicted result
    task automatic send_item(input logic [1:0] o, input logic [7:0] b, input logic f,
                             input logic m, input logic typed, input outcome_t typed_res,
                             output outcome_t pred);
        int gap;
        gap = 0;
        // a stretch in the middle runs without any idle cycles
        if ((sent_count < 300 || sent_count >= 520) && $urandom_range(0, 99) < 18)
            gap = $urandom_range(1, 8);
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        op <= o;
        rx_byte <= b;
        first_of_read <= f;
        mode_req <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = discipline_step(o, b, f, m);
        due_results.push_back(typed ? typed_res : pred);
        sent_count++;
    endtask

    task automatic key_in(input logic [7:0] b);
        outcome_t r;
        send_item(cld_pkg::OP_RX, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'b0, '0, r);
    endtask

    task automatic set_mode(input logic m);
        outcome_t r;
        send_item(cld_pkg::OP_MODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), m,
                  1'b0, '0, r);
    endtask

    // reads one byte at a time until the read call returns or would wait
    task automatic read_call(output cld_pkg::status_t last);
        outcome_t r;
        logic     fin;
        fin = 1'b0;
        while (!fin)
        begin
            send_item(cld_pkg::OP_READ, 8'($urandom_range(0, 255)), next_first,
                      1'($urandom_range(0, 1)), 1'b0, '0, r);
            last = r.status;
            if (r.done)
                next_first = 1'b1;
            else if (r.status != cld_pkg::ST_EMPTY)
                next_first = 1'b0;
            fin = r.done || r.status == cld_pkg::ST_EMPTY;
        end
    endtask

    task automatic drain_ring();
        cld_pkg::status_t last;
        last = cld_pkg::ST_DATA;
        while (last != cld_pkg::ST_EMPTY)
            read_call(last);
    endtask

    initial
    begin : stimulus
        outcome_t         r;
        cld_pkg::status_t last;
        int               pick;
        int               n;

        rst_n = 1'b0;
        start = 1'b0;
        op = cld_pkg::OP_RX;
        rx_byte = 8'h00;
        first_of_read = 1'b0;
        mode_req = 1'b0;
        mismatch_count = 0;
        sent_count = 0;
        next_first = 1'b1;
        rd_idx = 8'd0;
        cm_idx = 8'd0;
        ed_idx = 8'd0;
        raw_mode = 1'b0;

        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b1, 1'b0, 1'b1,
                              cld_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_MODE, 8'h00, 1'b0, 1'b1, 1'b1,
                              cld_pkg::ST_MODE_OK, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, 8'hFF, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_STORED, 0, 0, 0, 0, 1));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_DUMP, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_DUMP, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_EOF, 1'b1, 1'b1, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_MODE, 8'h00, 1'b1, 1'b1, 1'b1,
                              cld_pkg::ST_MODE_OK, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b1, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_MODE, 8'hFF, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_MODE_OK, 0, 0, 0, 0, 1));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_BS, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_ERASED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_KILL, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_ERASED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, 8'h00, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_DUMP, 1'b1, 1'b0, 1'b1,
                              cld_pkg::ST_DUMP, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, 8'hFF, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_ECHOED, 'hFF, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_MODE, 8'h00, 1'b0, 1'b1, 1'b1,
                              cld_pkg::ST_REFUSED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_DEL, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_KILL, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, 8'h62, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_CR, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_RX, cld_pkg::KEY_EOF, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b1, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b0,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 1'b1,
                              cld_pkg::ST_EOF_KEPT, 0, 0, 0, 1, 0));
        plan.push_back(mk_row(cld_pkg::OP_READ, 8'h00, 1'b1, 1'b0, 1'b1,
                              cld_pkg::ST_EOF, 0, 0, 0, 1, 0));
        plan.push_back(mk_row(OP_NONE, 8'hFF, 1'b1, 1'b1, 1'b1,
                              cld_pkg::ST_IGNORED, 0, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].op, plan[i].data, plan[i].first, plan[i].mode,
                      plan[i].typed, plan[i].res, r);

        while (sent_count < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // a cooked line with editing, then usually read back
                if (raw_mode)
                    set_mode(1'b0);
                n = $urandom_range(0, 12);
                repeat (n) key_in(edit_key());
                case ($urandom_range(0, 2))
                    0: key_in(cld_pkg::KEY_LF);
                    1: key_in(cld_pkg::KEY_CR);
                    default: key_in(cld_pkg::KEY_EOF);
                endcase
                if ($urandom_range(0, 9) < 7)
                    read_call(last);
            end
            else if (pick < 47)
            begin
                // long line wiped by kill, or trimmed by backspace
                if (raw_mode)
                    set_mode(1'b0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 127)
                                                : $urandom_range(10, 40);
                repeat (n) key_in(text_char());
                key_in(($urandom_range(0, 3) == 0) ? cld_pkg::KEY_BS : cld_pkg::KEY_KILL);
            end
            else if (pick < 49)
            begin
                // fill the ring past the top in cooked mode
                if (raw_mode)
                    set_mode(1'b0);
                repeat (LINE_RING_DEPTH + 2) key_in(text_char());
                key_in(cld_pkg::KEY_KILL);
                drain_ring();
            end
            else if (pick < 65)
            begin
                // raw session: needs an empty ring to enter
                if (raw_mode)
                    set_mode(1'b0);
                if ($urandom_range(0, 4) != 0)
                begin
                    key_in(cld_pkg::KEY_LF);
                    drain_ring();
                end
                set_mode(1'b1);
                n = ($urandom_range(0, 11) == 0) ? LINE_RING_DEPTH + 4 : $urandom_range(1, 20);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) < 7 || n > LINE_RING_DEPTH)
                        key_in(8'($urandom_range(0, 255)));
                    else
                        read_call(last);
                end
                if ($urandom_range(0, 1) == 0)
                    drain_ring();
                set_mode(1'b0);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0, r);
            end
            else
            begin
                drain_ring();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (LINE_RING_DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/cld_pkg.sv
design/cld_front.sv
design/cld_queue.sv
design/cld_back.sv
design/console_line_discipline_top.sv
design/cld_checker.sv
tb/tb_console_line_discipline_top.sv
